[hw/rtl/mcar_pkg.sv]
`default_nettype none

package mcar_pkg;

   // Fixed point and storage sizes
   localparam int FRAC_BITS         = 16;
   localparam int DATA_W            = 18;
   localparam int NUM_INSTANCES     = 16;
   localparam int INST_W            = $clog2(NUM_INSTANCES);
   localparam int ACTION_W          = 2;
   localparam int COS_TABLE_ENTRIES = 1024;
   localparam int COS_IDX_W         = $clog2(COS_TABLE_ENTRIES);
   localparam int COS_W             = FRAC_BITS + 2;

   // Register widths
   localparam int VEL_MIN_W  = 17;
   localparam int VEL_MAX_W  = 17;
   localparam int POS_MIN_W  = 18;
   localparam int POS_MAX_W  = 17;
   localparam int FORCE_W    = 11;
   localparam int GRAV_W     = 13;
   localparam int CSR_DATA_W = 18;
   localparam int CSR_ADDR_W = 3;

   // Stream word layout
   localparam int REQ_TUSER_W  = 2;
   localparam int REQ_INST_LSB = 0;
   localparam int ACTION_LSB   = REQ_INST_LSB + INST_W;
   localparam int SVEL_LSB     = ACTION_LSB + ACTION_W;
   localparam int SPOS_LSB     = SVEL_LSB + DATA_W;
   localparam int REQ_FIELDS_W = SPOS_LSB + DATA_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = INST_W + 2 * DATA_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [1:0] {
      REQ_ADVANCE = 2'd0,
      REQ_LOAD    = 2'd1,
      REQ_RESTART = 2'd2
   } req_kind_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_BACK = 2'd0,
      ACT_NONE = 2'd1,
      ACT_FWD  = 2'd2
   } action_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_VEL_MIN   = 3'd0,
      CSR_VEL_MAX   = 3'd1,
      CSR_POS_MIN   = 3'd2,
      CSR_POS_MAX   = 3'd3,
      CSR_FORCE     = 3'd4,
      CSR_GRAVITY   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] position;
      logic signed [DATA_W-1:0] velocity;
   } car_state_type;

   typedef struct packed {
      logic signed [VEL_MIN_W-1:0] vel_min;
      logic        [VEL_MAX_W-1:0] vel_max;
      logic signed [POS_MIN_W-1:0] pos_min;
      logic        [POS_MAX_W-1:0] pos_max;
      logic        [FORCE_W-1:0]   force_gain;
      logic        [GRAV_W-1:0]    gravity_gain;
   } mcar_cfg_type;

   localparam mcar_cfg_type CFG_RESET = '{
      vel_min:      VEL_MIN_W'(-4588),
      vel_max:      VEL_MAX_W'(4588),
      pos_min:      POS_MIN_W'(-78643),
      pos_max:      POS_MAX_W'(45875),
      force_gain:   FORCE_W'(66),
      gravity_gain: GRAV_W'(164)
   };

   // Cars start at rest at position -0.5
   localparam car_state_type CAR_RESET = '{
      position: DATA_W'(-(1 <<< (FRAC_BITS - 1))),
      velocity: '0
   };

   // cos(3x) table, built at elaboration with a Q30 Taylor series and stored in Q16
   typedef longint unsigned u64_type;
   typedef logic signed [COS_W-1:0] cos_rom_type [COS_TABLE_ENTRIES];

   localparam u64_type Q30_PI      = 64'd3373259426;
   localparam u64_type Q30_HALF_PI = 64'd1686629713;
   localparam u64_type Q30_TWO_PI  = 64'd6746518852;
   localparam u64_type TAYLOR_DIV [7] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                          64'd132, 64'd182};

   function automatic logic signed [COS_W-1:0] cos_entry(input int unsigned idx);
      longint  x;
      longint  theta;
      longint  sum;
      u64_type a;
      u64_type a2;
      u64_type t;
      u64_type mag;
      logic    neg;
      x = longint'(((u64_type'(idx) * 64'd2 + 64'd1) << 31) / COS_TABLE_ENTRIES)
          - (64'sd1 <<< 31);
      theta = 3 * x;
      a = (theta < 0) ? u64_type'(-theta) : u64_type'(theta);
      neg = 1'b0;
      while (a >= Q30_TWO_PI)
         a = a - Q30_TWO_PI;
      if (a > Q30_PI)
         a = Q30_TWO_PI - a;
      if (a > Q30_HALF_PI) begin
         a = Q30_PI - a;
         neg = 1'b1;
      end
      a2 = (a * a) >> 30;
      t = 64'd1 << 30;
      sum = longint'(t);
      for (int k = 1; k <= 7; k++) begin
         t = (t * a2) >> 30;
         t = t / TAYLOR_DIV[k-1];
         if ((k & 1) == 1)
            sum = sum - longint'(t);
         else
            sum = sum + longint'(t);
      end
      if (sum < 0)
         sum = 0;
      mag = (u64_type'(sum) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      return neg ? -COS_W'(mag) : COS_W'(mag);
   endfunction

   function automatic cos_rom_type build_cos_rom();
      cos_rom_type rom;
      for (int i = 0; i < COS_TABLE_ENTRIES; i++)
         rom[i] = cos_entry(i);
      return rom;
   endfunction

   localparam cos_rom_type COS_ROM = build_cos_rom();

endpackage

`default_nettype wire

[hw/rtl/mountain_car_env_step_core.sv]
`default_nettype none
// An accepted word passes the compute stage register, then the result register.
// Throughput: one word per cycle unless the result side stalls; a word for the car
// in the compute stage waits until that word has written the car state back.
// Reset (synchronous): config registers take their defaults, every car is at
// rest at position -0.5 with the same start pair, and both channels are empty.

module mountain_car_env_step_core import mcar_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // [3:0] instance_req, [5:4] action, [23:6] start_velocity, [41:24] start_position
   input  wire logic [REQ_TDATA_W-1:0]   req_tdata,
   // [1:0] req_type
   input  wire logic [REQ_TUSER_W-1:0]   req_tuser,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // [3:0] instance_out, [21:4] velocity, [39:22] position
   output logic [RSP_TDATA_W-1:0]        rsp_tdata,
   input  wire logic                     csr_we,
   input  wire logic [CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [CSR_DATA_W-1:0]    csr_wdata
);

   // config
   mcar_cfg_type cfg_ff;
   mcar_cfg_type cfg_in;

   // per-car state
   car_state_type cur_ff   [NUM_INSTANCES];
   car_state_type cur_in   [NUM_INSTANCES];
   car_state_type start_ff [NUM_INSTANCES];
   car_state_type start_in [NUM_INSTANCES];

   // compute stage
   logic                      s2_valid_ff;
   logic                      s2_valid_in;
   req_kind_type              s2_type_ff;
   req_kind_type              s2_type_in;
   logic [INST_W-1:0]         s2_inst_ff;
   logic [INST_W-1:0]         s2_inst_in;
   logic [ACTION_W-1:0]       s2_action_ff;
   logic [ACTION_W-1:0]       s2_action_in;
   car_state_type             s2_load_ff;
   car_state_type             s2_load_in;
   car_state_type             s2_cur_ff;
   car_state_type             s2_cur_in;
   car_state_type             s2_start_ff;
   car_state_type             s2_start_in;

   // result register
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [INST_W-1:0]         rsp_inst_ff;
   logic [INST_W-1:0]         rsp_inst_in;
   car_state_type             rsp_state_ff;
   car_state_type             rsp_state_in;

   logic [INST_W-1:0]         req_inst;
   logic                      req_accept;
   logic                      s2_move;
   logic                      same_car;
   logic signed [COS_W-1:0]   cos_val;
   logic [COS_IDX_W-1:0]      cos_addr;
   car_state_type             req_car;
   car_state_type             adv_state;
   car_state_type             cur_next;
   car_state_type             start_next;

   // config writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_VEL_MIN: cfg_in.vel_min      = csr_wdata[VEL_MIN_W-1:0];
            CSR_VEL_MAX: cfg_in.vel_max      = csr_wdata[VEL_MAX_W-1:0];
            CSR_POS_MIN: cfg_in.pos_min      = csr_wdata[POS_MIN_W-1:0];
            CSR_POS_MAX: cfg_in.pos_max      = csr_wdata[POS_MAX_W-1:0];
            CSR_FORCE:   cfg_in.force_gain   = csr_wdata[FORCE_W-1:0];
            CSR_GRAVITY: cfg_in.gravity_gain = csr_wdata[GRAV_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // handshake: a word may not enter while its car is still in the compute stage
   assign req_inst   = req_tdata[REQ_INST_LSB +: INST_W];
   assign same_car   = s2_valid_ff && (s2_inst_ff == req_inst);
   assign s2_move    = s2_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (!s2_valid_ff || s2_move) && !same_car;
   assign req_accept = req_tvalid && req_tready;

   // state read for the incoming word; table index is the top position bits
   assign req_car  = cur_ff[req_inst];
   assign cos_addr = {~req_car.position[DATA_W-1],
                      req_car.position[DATA_W-2 -: COS_IDX_W-1]};

   mcar_cos_rom u_cos_rom (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (cos_addr),
      .rd_data (cos_val)
   );

   // compute stage valid
   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (req_accept)
         s2_valid_in = 1'b1;
      else if (s2_move)
         s2_valid_in = 1'b0;
   end

   // compute stage payload
   always_comb begin
      s2_type_in   = s2_type_ff;
      s2_inst_in   = s2_inst_ff;
      s2_action_in = s2_action_ff;
      s2_load_in   = s2_load_ff;
      s2_cur_in    = s2_cur_ff;
      s2_start_in  = s2_start_ff;
      if (req_accept) begin
         s2_type_in          = req_kind_type'(req_tuser[1:0]);
         s2_inst_in          = req_inst;
         s2_action_in        = req_tdata[ACTION_LSB +: ACTION_W];
         s2_load_in.velocity = req_tdata[SVEL_LSB +: DATA_W];
         s2_load_in.position = req_tdata[SPOS_LSB +: DATA_W];
         s2_cur_in           = req_car;
         s2_start_in         = start_ff[req_inst];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_type_ff   <= s2_type_in;
      s2_inst_ff   <= s2_inst_in;
      s2_action_ff <= s2_action_in;
      s2_load_ff   <= s2_load_in;
      s2_cur_ff    <= s2_cur_in;
      s2_start_ff  <= s2_start_in;
   end

   mcar_dyn u_dyn (
      .cfg     (cfg_ff),
      .cur     (s2_cur_ff),
      .cos_val (cos_val),
      .action  (s2_action_ff),
      .nxt     (adv_state)
   );

   // operation select
   always_comb begin
      cur_next   = s2_cur_ff;
      start_next = s2_start_ff;
      case (s2_type_ff)
         REQ_ADVANCE: cur_next   = adv_state;
         REQ_LOAD:    start_next = s2_load_ff;
         REQ_RESTART: cur_next   = s2_start_ff;
         default:     cur_next   = s2_cur_ff;
      endcase
   end

   // state write-back when the word leaves the compute stage
   always_comb begin
      cur_in   = cur_ff;
      start_in = start_ff;
      if (s2_move) begin
         cur_in[s2_inst_ff]   = cur_next;
         start_in[s2_inst_ff] = start_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_INSTANCES; i++) begin
            cur_ff[i]   <= CAR_RESET;
            start_ff[i] <= CAR_RESET;
         end
      end else begin
         cur_ff   <= cur_in;
         start_ff <= start_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_inst_in  = rsp_inst_ff;
      rsp_state_in = rsp_state_ff;
      if (s2_move) begin
         rsp_valid_in = 1'b1;
         rsp_inst_in  = s2_inst_ff;
         rsp_state_in = cur_next;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_inst_ff  <= rsp_inst_in;
      rsp_state_ff <= rsp_state_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_state_ff, rsp_inst_ff});

`ifndef SYNTHESIS
   // a new word never lands on an unfinished one in the compute stage
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_accept && s2_valid_ff |-> s2_move)
      else $error("compute stage overwritten");

   // no word enters while the same car is being updated
   a_no_stale_read: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> !(s2_valid_ff && (s2_inst_ff == req_inst)))
      else $error("stale car state read");

   // table word stays with a stalled word
   a_cos_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_move |=> $stable(cos_val))
      else $error("table word changed under stalled word");

   // a word leaving the compute stage shows up at the result port
   a_result_out: assert property (@(posedge clock) disable iff (reset)
      s2_move |=> rsp_tvalid && (rsp_inst_ff == $past(s2_inst_ff)))
      else $error("result word lost");

   // with ordered limits an advanced position stays inside them
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      s2_move && (s2_type_ff == REQ_ADVANCE)
         && (cfg_ff.pos_min <= $signed({1'b0, cfg_ff.pos_max}))
      |-> (adv_state.position >= cfg_ff.pos_min)
         && (adv_state.position <= $signed({1'b0, cfg_ff.pos_max})))
      else $error("position outside limits");
`endif

endmodule

`default_nettype wire

[hw/rtl/mcar_cos_rom.sv]
`default_nettype none

module mcar_cos_rom import mcar_pkg::*; (
   input  wire logic                        clock,
   input  wire logic                        rd_en,
   input  wire logic [COS_IDX_W-1:0]        rd_addr,
   output logic signed [COS_W-1:0]          rd_data
);

   logic signed [COS_W-1:0] rd_data_ff;
   logic signed [COS_W-1:0] rd_data_in;

   // registered read, holds while not enabled
   always_comb begin
      rd_data_in = rd_data_ff;
      if (rd_en)
         rd_data_in = COS_ROM[rd_addr];
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= rd_data_in;
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hw/rtl/mcar_dyn.sv]
`default_nettype none

module mcar_dyn import mcar_pkg::*; (
   input  wire mcar_cfg_type                cfg,
   input  wire car_state_type               cur,
   input  wire logic signed [COS_W-1:0]     cos_val,
   input  wire logic [ACTION_W-1:0]         action,
   output car_state_type                    nxt
);

   localparam int PROD_W = GRAV_W + 1 + COS_W;
   localparam int GTERM_W = PROD_W - FRAC_BITS;
   localparam int VSUM_W = DATA_W + 2;
   localparam int PSUM_W = DATA_W + 1;

   logic signed [PROD_W-1:0]  grav_prod;
   logic signed [PROD_W-1:0]  grav_rnd;
   logic signed [GTERM_W-1:0] grav_term;
   logic signed [VSUM_W-1:0]  push_term;
   logic signed [VSUM_W-1:0]  vel_sum;
   logic signed [VSUM_W-1:0]  vel_lo;
   logic signed [VSUM_W-1:0]  vel_clamp;
   logic signed [VSUM_W-1:0]  vmin_x;
   logic signed [VSUM_W-1:0]  vmax_x;
   logic signed [PSUM_W-1:0]  pos_sum;
   logic signed [PSUM_W-1:0]  pos_lo;
   logic signed [PSUM_W-1:0]  pos_clamp;
   logic signed [PSUM_W-1:0]  pmin_x;
   logic signed [PSUM_W-1:0]  pmax_x;

   // gravity: gain * cos(3p), rounded half up to the fraction point
   assign grav_prod = $signed({1'b0, cfg.gravity_gain}) * cos_val;
   assign grav_rnd  = grav_prod + PROD_W'(1 <<< (FRAC_BITS - 1));
   assign grav_term = grav_rnd[PROD_W-1:FRAC_BITS];

   // push; action code three pushes forward
   always_comb begin
      case (action)
         ACT_BACK: push_term = -$signed(VSUM_W'(cfg.force_gain));
         ACT_NONE: push_term = '0;
         default:  push_term = $signed(VSUM_W'(cfg.force_gain));
      endcase
   end

   // velocity update, upper clamp applied last
   assign vmin_x  = VSUM_W'(cfg.vel_min);
   assign vmax_x  = $signed(VSUM_W'(cfg.vel_max));
   assign vel_sum = VSUM_W'(cur.velocity) + push_term - VSUM_W'(grav_term);
   assign vel_lo    = (vel_sum < vmin_x) ? vmin_x : vel_sum;
   assign vel_clamp = (vel_lo > vmax_x) ? vmax_x : vel_lo;

   // position update with the new velocity
   assign pmin_x  = PSUM_W'(cfg.pos_min);
   assign pmax_x  = $signed(PSUM_W'(cfg.pos_max));
   assign pos_sum = PSUM_W'(cur.position) + PSUM_W'($signed(vel_clamp[DATA_W-1:0]));
   assign pos_lo    = (pos_sum < pmin_x) ? pmin_x : pos_sum;
   assign pos_clamp = (pos_lo > pmax_x) ? pmax_x : pos_lo;

   assign nxt.velocity = vel_clamp[DATA_W-1:0];
   assign nxt.position = pos_clamp[DATA_W-1:0];

endmodule

`default_nettype wire

[tb/tb_mountain_car_env_step_core.sv]
`default_nettype none

module tb_mountain_car_env_step_core;
   import mcar_pkg::*;

   typedef longint unsigned wide_u_type;

   // Request kind and push codes that the package leaves unnamed
   localparam logic [1:0]          REQ_UNUSED   = 2'd3;
   localparam logic [ACTION_W-1:0] ACT_OVER_FWD = 2'd3;

   localparam wide_u_type PI_Q30      = 64'd3373259426;
   localparam wide_u_type HALF_PI_Q30 = 64'd1686629713;
   localparam wide_u_type TWO_PI_Q30  = 64'd6746518852;

   localparam int unsigned STALL_LIMIT = 2000;

   localparam mcar_cfg_type CFG_WIDE = '{
      vel_min:      VEL_MIN_W'(-65536),
      vel_max:      VEL_MAX_W'(65536),
      pos_min:      POS_MIN_W'(-131072),
      pos_max:      POS_MAX_W'(131071),
      force_gain:   FORCE_W'(1024),
      gravity_gain: GRAV_W'(4096)
   };
   // Lower limits above the upper ones
   localparam mcar_cfg_type CFG_CROSSED = '{
      vel_min:      VEL_MIN_W'(3000),
      vel_max:      VEL_MAX_W'(1000),
      pos_min:      POS_MIN_W'(20000),
      pos_max:      POS_MAX_W'(5000),
      force_gain:   FORCE_W'(1024),
      gravity_gain: GRAV_W'(4096)
   };
   localparam mcar_cfg_type CFG_ZERO = '0;

   typedef struct {
      logic [1:0]               kind;
      logic [INST_W-1:0]        car;
      logic [ACTION_W-1:0]      push;
      logic signed [DATA_W-1:0] v0;
      logic signed [DATA_W-1:0] p0;
   } car_request_type;

   typedef struct {
      logic [INST_W-1:0]        car;
      logic signed [DATA_W-1:0] velocity;
      logic signed [DATA_W-1:0] position;
   } car_report_type;

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata  = '0;
   logic [REQ_TUSER_W-1:0]  req_tuser  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr   = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   // Predictor state
   mcar_cfg_type             car_cfg;
   logic signed [DATA_W-1:0] cur_vel  [NUM_INSTANCES];
   logic signed [DATA_W-1:0] cur_pos  [NUM_INSTANCES];
   logic signed [DATA_W-1:0] home_vel [NUM_INSTANCES];
   logic signed [DATA_W-1:0] home_pos [NUM_INSTANCES];
   longint                   cos3_lut [COS_TABLE_ENTRIES];

   car_report_type pending_reports [$];
   int unsigned mismatches   = 0;
   int unsigned quiet_cycles = 0;
   int unsigned hold_req     = 0;
   int unsigned hold_left    = 0;
   int unsigned stall_left   = 0;
   bit          calm         = 1'b0;

   mountain_car_env_step_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // cos(3x) at the center of table bin, Taylor series in Q30
   function automatic longint cos3_at(input int unsigned entry);
      longint     x;
      longint     theta;
      longint     acc;
      wide_u_type ang;
      wide_u_type ang2;
      wide_u_type term;
      wide_u_type mag;
      bit         flip;
      x = longint'(((64'd2 * entry + 64'd1) << 31) / COS_TABLE_ENTRIES)
          - (longint'(1) << 31);
      theta = 3 * x;
      ang = (theta < 0) ? wide_u_type'(-theta) : wide_u_type'(theta);
      flip = 1'b0;
      while (ang >= TWO_PI_Q30)
         ang = ang - TWO_PI_Q30;
      if (ang > PI_Q30)
         ang = TWO_PI_Q30 - ang;
      if (ang > HALF_PI_Q30) begin
         ang = PI_Q30 - ang;
         flip = 1'b1;
      end
      ang2 = (ang * ang) >> 30;
      term = 64'd1 << 30;
      acc = longint'(term);
      for (int k = 1; k <= 7; k++) begin
         term = (term * ang2) >> 30;
         term = term / wide_u_type'((2 * k - 1) * (2 * k));
         if (k % 2 == 1)
            acc = acc - longint'(term);
         else
            acc = acc + longint'(term);
      end
      if (acc < 0)
         acc = 0;
      mag = (wide_u_type'(acc) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      return flip ? -longint'(mag) : longint'(mag);
   endfunction

   // Apply one request to the predicted cars and return the expected word
   function automatic car_report_type step_car(input car_request_type rq);
      car_report_type rep;
      longint         push;
      longint         u;
      longint         grav;
      longint         v;
      longint         p;
      longint         idx;
      case (rq.kind)
         REQ_ADVANCE: begin
            if (rq.push == ACT_OVER_FWD)
               push = 1;
            else
               push = longint'(rq.push) - 1;
            // table index from position, saturated to [-2,2)
            u = longint'(cur_pos[rq.car]) + (longint'(1) << (FRAC_BITS + 1));
            if (u < 0)
               u = 0;
            if (u > (longint'(1) << (FRAC_BITS + 2)) - 1)
               u = (longint'(1) << (FRAC_BITS + 2)) - 1;
            idx = (u * COS_TABLE_ENTRIES) >>> (FRAC_BITS + 2);
            if (idx >= COS_TABLE_ENTRIES)
               idx = COS_TABLE_ENTRIES - 1;
            grav = (longint'(car_cfg.gravity_gain) * cos3_lut[idx[COS_IDX_W-1:0]]
                    + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
            v = longint'(cur_vel[rq.car]) + longint'(car_cfg.force_gain) * push - grav;
            // upper clamp last, so it wins when the limits cross
            if (v < longint'($signed(car_cfg.vel_min)))
               v = longint'($signed(car_cfg.vel_min));
            if (v > longint'(car_cfg.vel_max))
               v = longint'(car_cfg.vel_max);
            p = longint'(cur_pos[rq.car]) + v;
            if (p < longint'($signed(car_cfg.pos_min)))
               p = longint'($signed(car_cfg.pos_min));
            if (p > longint'(car_cfg.pos_max))
               p = longint'(car_cfg.pos_max);
            cur_vel[rq.car] = v[DATA_W-1:0];
            cur_pos[rq.car] = p[DATA_W-1:0];
         end
         REQ_LOAD: begin
            home_vel[rq.car] = rq.v0;
            home_pos[rq.car] = rq.p0;
         end
         REQ_RESTART: begin
            cur_vel[rq.car] = home_vel[rq.car];
            cur_pos[rq.car] = home_pos[rq.car];
         end
         default: ;
      endcase
      rep.car      = rq.car;
      rep.velocity = cur_vel[rq.car];
      rep.position = cur_pos[rq.car];
      return rep;
   endfunction

   // Mostly no gap, some short ones, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 70)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic mcar_cfg_type rand_cfg();
      mcar_cfg_type c;
      c.vel_min      = VEL_MIN_W'(-int'($urandom_range(0, 65536)));
      c.vel_max      = VEL_MAX_W'($urandom_range(0, 65536));
      c.pos_min      = POS_MIN_W'(-int'($urandom_range(0, 131072)));
      c.pos_max      = POS_MAX_W'($urandom_range(0, 131071));
      c.force_gain   = FORCE_W'($urandom_range(0, 1024));
      c.gravity_gain = GRAV_W'($urandom_range(0, 4096));
      return c;
   endfunction

   task automatic report_mismatch(input string field, input longint want, input longint got);
      $display("mismatch in %s at %0t: expected %0d, got %0d", field, $time, want, got);
      mismatches++;
   endtask

   // Offer one request word; called and returns at a falling edge
   task automatic send_word(input logic [1:0] kind, input logic [INST_W-1:0] car,
                            input logic [ACTION_W-1:0] act,
                            input logic signed [DATA_W-1:0] v0,
                            input logic signed [DATA_W-1:0] p0);
      car_request_type        rq;
      int unsigned            gap;
      logic [REQ_TDATA_W-1:0] word;
      rq.kind = kind;
      rq.car  = car;
      rq.push = act;
      rq.v0   = v0;
      rq.p0   = p0;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      word = '0;
      word[REQ_INST_LSB +: INST_W] = car;
      word[ACTION_LSB +: ACTION_W] = act;
      word[SVEL_LSB +: DATA_W]     = v0;
      word[SPOS_LSB +: DATA_W]     = p0;
      req_tdata  <= word;
      req_tuser  <= kind;
      req_tvalid <= 1'b1;
      forever begin
         @(posedge clock);
         if (req_tready)
            break;
      end
      pending_reports.push_back(step_car(rq));
      @(negedge clock);
   endtask

   // Drop valid and wait until every expected word has come out
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_reports.size() != 0)
         @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic set_config(input mcar_cfg_type c);
      csr_index_type          ix;
      logic [CSR_DATA_W-1:0]  wd;
      wait_idle();
      ix = ix.first();
      repeat (ix.num()) begin
         case (ix)
            CSR_VEL_MIN: wd = CSR_DATA_W'($signed(c.vel_min));
            CSR_VEL_MAX: wd = CSR_DATA_W'(c.vel_max);
            CSR_POS_MIN: wd = CSR_DATA_W'($signed(c.pos_min));
            CSR_POS_MAX: wd = CSR_DATA_W'(c.pos_max);
            CSR_FORCE:   wd = CSR_DATA_W'(c.force_gain);
            default:     wd = CSR_DATA_W'(c.gravity_gain);
         endcase
         csr_addr  <= ix;
         csr_wdata <= wd;
         csr_we    <= 1'b1;
         @(posedge clock);
         @(negedge clock);
         ix = ix.next();
      end
      csr_we  <= 1'b0;
      car_cfg = c;
   endtask

   // Mostly advances, with loads, restarts and unused kinds mixed in
   task automatic random_items(input int unsigned n, input bit vary_idle);
      int unsigned              r;
      logic [1:0]               kind;
      logic [INST_W-1:0]        focus;
      logic [INST_W-1:0]        car;
      logic signed [DATA_W-1:0] v0;
      focus = INST_W'($urandom);
      for (int unsigned i = 0; i < n; i++) begin
         if (i % 40 == 0) begin
            if (vary_idle)
               calm = ($urandom_range(0, 99) < 25);
            focus = INST_W'($urandom);
         end
         r = $urandom_range(0, 99);
         if (r < 65)
            kind = REQ_ADVANCE;
         else if (r < 80)
            kind = REQ_LOAD;
         else if (r < 95)
            kind = REQ_RESTART;
         else
            kind = REQ_UNUSED;
         // keep hitting a pair of cars so back-to-back words collide
         if ($urandom_range(0, 1) == 1)
            car = focus ^ INST_W'($urandom_range(0, 1));
         else
            car = INST_W'($urandom);
         if ($urandom_range(0, 99) < 70)
            v0 = DATA_W'(int'($urandom_range(0, 131072)) - 65536);
         else
            v0 = DATA_W'($urandom);
         send_word(kind, car, ACTION_W'($urandom), v0, DATA_W'($urandom));
      end
   endtask

   task automatic test_reset_state();
      send_word(REQ_RESTART, INST_W'(0), ACT_NONE, '0, '0);
      send_word(REQ_UNUSED, INST_W'(1), ACT_NONE, '0, '0);
      send_word(REQ_ADVANCE, INST_W'(2), ACT_BACK, '0, '0);
      send_word(REQ_ADVANCE, INST_W'(2), ACT_NONE, '0, '0);
      send_word(REQ_ADVANCE, INST_W'(2), ACT_FWD, '0, '0);
      send_word(REQ_ADVANCE, INST_W'(2), ACT_OVER_FWD, '0, '0);
      send_word(REQ_ADVANCE, INST_W'(15), ACT_NONE, '0, '0);
   endtask

   // Start pairs at the ends of the field range, stored without clamping
   task automatic test_load_extremes();
      send_word(REQ_LOAD, INST_W'(3), ACT_NONE, DATA_W'(131071), DATA_W'(-131072));
      send_word(REQ_ADVANCE, INST_W'(3), ACT_NONE, '0, '0);
      send_word(REQ_RESTART, INST_W'(3), ACT_NONE, '0, '0);
      send_word(REQ_ADVANCE, INST_W'(3), ACT_FWD, '0, '0);
      send_word(REQ_LOAD, INST_W'(4), ACT_BACK, DATA_W'(-131072), DATA_W'(131071));
      send_word(REQ_RESTART, INST_W'(4), ACT_NONE, '0, '0);
      send_word(REQ_ADVANCE, INST_W'(4), ACT_BACK, '0, '0);
      send_word(REQ_UNUSED, INST_W'(4), ACT_FWD, '0, '0);
   endtask

   task automatic test_clamp_extremes();
      set_config(CFG_WIDE);
      send_word(REQ_RESTART, INST_W'(3), ACT_NONE, '0, '0);
      send_word(REQ_ADVANCE, INST_W'(3), ACT_FWD, '0, '0);
      send_word(REQ_RESTART, INST_W'(4), ACT_NONE, '0, '0);
      send_word(REQ_ADVANCE, INST_W'(4), ACT_OVER_FWD, '0, '0);
      set_config(CFG_CROSSED);
      send_word(REQ_ADVANCE, INST_W'(3), ACT_BACK, '0, '0);
      send_word(REQ_ADVANCE, INST_W'(4), ACT_NONE, '0, '0);
      set_config(CFG_ZERO);
      send_word(REQ_ADVANCE, INST_W'(5), ACT_FWD, '0, '0);
   endtask

   task automatic test_random_phases();
      set_config(CFG_RESET);
      random_items(140, 1'b1);
      set_config(CFG_WIDE);
      random_items(80, 1'b1);
      set_config(rand_cfg());
      random_items(70, 1'b1);
      set_config(rand_cfg());
      random_items(70, 1'b1);
      set_config(CFG_CROSSED);
      random_items(30, 1'b1);
      set_config(CFG_ZERO);
      random_items(20, 1'b1);
   endtask

   // Receiver holds off for a long stretch while requests keep coming
   task automatic test_backpressure();
      set_config(CFG_RESET);
      calm     = 1'b1;
      hold_req = 200;
      random_items(24, 1'b0);
      calm = 1'b0;
   endtask

   // Result side: ready pattern, driven at the falling edge
   always @(negedge clock) begin
      if (hold_req != 0) begin
         hold_left = hold_req;
         hold_req  = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         stall_left = pick_gap();
         rsp_tready <= (stall_left == 0);
         if (stall_left != 0)
            stall_left--;
      end
   end

   // Compare each result word with the oldest expectation
   always @(posedge clock) begin
      car_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            report_mismatch("word with nothing pending, car", -1,
                            longint'(rsp_tdata[0 +: INST_W]));
         end else begin
            want = pending_reports.pop_front();
            if (rsp_tdata[0 +: INST_W] !== want.car)
               report_mismatch("instance", longint'(want.car),
                               longint'(rsp_tdata[0 +: INST_W]));
            if (rsp_tdata[INST_W +: DATA_W] !== want.velocity)
               report_mismatch("velocity", longint'(want.velocity),
                               longint'($signed(rsp_tdata[INST_W +: DATA_W])));
            if (rsp_tdata[INST_W + DATA_W +: DATA_W] !== want.position)
               report_mismatch("position", longint'(want.position),
                               longint'($signed(rsp_tdata[INST_W + DATA_W +: DATA_W])));
         end
      end
   end

   // Watchdog: too long without a word moving on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      foreach (cos3_lut[i])
         cos3_lut[i] = cos3_at(i);
      car_cfg = CFG_RESET;
      foreach (cur_vel[i]) begin
         cur_vel[i]  = CAR_RESET.velocity;
         cur_pos[i]  = CAR_RESET.position;
         home_vel[i] = CAR_RESET.velocity;
         home_pos[i] = CAR_RESET.position;
      end
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_load_extremes();
      test_clamp_extremes();
      test_random_phases();
      test_backpressure();

      wait_idle();
      repeat (5) @(posedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/mcar_pkg.sv
hw/rtl/mcar_cos_rom.sv
hw/rtl/mcar_dyn.sv
hw/rtl/mountain_car_env_step_core.sv
tb/tb_mountain_car_env_step_core.sv
